// ===== src/scl_pkg.sv =====
package scl_pkg;

    localparam int COORD_BITS_DEF  = 16;
    localparam int U_FRAC_BITS_DEF = 16;
    localparam int TOL_BITS        = 15;
    localparam int N_LANES         = 4;

    localparam int LANE_ENTER_X = 0;
    localparam int LANE_LEAVE_X = 1;
    localparam int LANE_ENTER_Y = 2;
    localparam int LANE_LEAVE_Y = 3;

    typedef struct packed {
        logic ok;
        logic neg_x;
        logic neg_y;
    } t_flags;

endpackage

// ===== src/scl_if.sv =====
interface scl_seg_if #(
    parameter int COORD_BITS = scl_pkg::COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
    logic signed [COORD_BITS-1:0] rect_left;
    logic signed [COORD_BITS-1:0] rect_top;
    logic        [COORD_BITS-2:0] rect_width;
    logic        [COORD_BITS-2:0] rect_height;

    modport source (output valid, start_x, start_y, end_x, end_y, rect_left, rect_top,
                    rect_width, rect_height, input ready);
    modport sink   (input valid, start_x, start_y, end_x, end_y, rect_left, rect_top,
                    rect_width, rect_height, output ready);
endinterface

interface scl_res_if #(
    parameter int COORD_BITS = scl_pkg::COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic                         hit;
    logic signed [COORD_BITS-1:0] entry_x;
    logic signed [COORD_BITS-1:0] entry_y;

    modport source (output valid, hit, entry_x, entry_y, input ready);
    modport sink   (input valid, hit, entry_x, entry_y, output ready);
endinterface

// ===== src/scl_front.sv =====
module scl_front #(
    parameter int COORD_BITS  = scl_pkg::COORD_BITS_DEF,
    parameter int U_FRAC_BITS = scl_pkg::U_FRAC_BITS_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_en,
    input  logic                                    i_valid,
    input  logic signed [COORD_BITS-1:0]            i_sx,
    input  logic signed [COORD_BITS-1:0]            i_sy,
    input  logic signed [COORD_BITS-1:0]            i_ex,
    input  logic signed [COORD_BITS-1:0]            i_ey,
    input  logic signed [COORD_BITS-1:0]            i_rl,
    input  logic signed [COORD_BITS-1:0]            i_rt,
    input  logic        [COORD_BITS-2:0]            i_rw,
    input  logic        [COORD_BITS-2:0]            i_rh,
    output logic                                    o_valid,
    output scl_pkg::t_flags                         o_flags,
    output logic signed [COORD_BITS-1:0]            o_sx,
    output logic signed [COORD_BITS-1:0]            o_sy,
    output logic        [COORD_BITS-1:0]            o_adx,
    output logic        [COORD_BITS-1:0]            o_ady,
    output logic [scl_pkg::N_LANES-1:0][COORD_BITS-1:0] o_rem,
    output logic [scl_pkg::N_LANES-1:0][COORD_BITS-1:0] o_den,
    output logic [scl_pkg::N_LANES-1:0]             o_ov,
    output logic [scl_pkg::N_LANES-1:0][U_FRAC_BITS+1:0] o_ovv
);
    import scl_pkg::*;

    localparam int C  = COORD_BITS;
    localparam int U  = U_FRAC_BITS;
    localparam int QW = C + 3;
    localparam logic [U+1:0] ONE     = (U+2)'(1) << U;
    localparam logic [U+1:0] ONE_P1  = ONE + (U+2)'(1);

    logic signed [C:0]     dx, dy;
    logic        [C:0]     adx_w, ady_w;
    logic signed [QW-1:0]  q [N_LANES];
    logic        [C-1:0]   dd [2];
    logic                  neg [2];
    logic signed [QW-1:0]  dq, eq, lq, en_n;
    logic                  ok;
    logic [N_LANES-1:0][C-1:0] rem, den;
    logic [N_LANES-1:0]        ov;
    logic [N_LANES-1:0][U+1:0] ovv;

    always_comb begin
        dx    = {i_ex[C-1], i_ex} - {i_sx[C-1], i_sx};
        dy    = {i_ey[C-1], i_ey} - {i_sy[C-1], i_sy};
        adx_w = dx[C] ? -dx : dx;
        ady_w = dy[C] ? -dy : dy;
        q[LANE_ENTER_X] = {{3{i_sx[C-1]}}, i_sx} - {{3{i_rl[C-1]}}, i_rl};
        q[LANE_LEAVE_X] = {{3{i_rl[C-1]}}, i_rl} + {4'b0, i_rw} - {{3{i_sx[C-1]}}, i_sx};
        q[LANE_ENTER_Y] = {{3{i_sy[C-1]}}, i_sy} - {{3{i_rt[C-1]}}, i_rt};
        q[LANE_LEAVE_Y] = {{3{i_rt[C-1]}}, i_rt} + {4'b0, i_rh} - {{3{i_sy[C-1]}}, i_sy};
        dd[0]  = adx_w[C-1:0];
        dd[1]  = ady_w[C-1:0];
        neg[0] = dx[C];
        neg[1] = dy[C];
        ok     = 1'b1;
        dq = '0;
        eq = '0;
        lq = '0;
        en_n = '0;
        for (int a = 0; a < 2; a++) begin
            rem[2*a]   = '0;
            den[2*a]   = C'(1);
            ov[2*a]    = 1'b1;
            ovv[2*a]   = '0;
            rem[2*a+1] = '0;
            den[2*a+1] = C'(1);
            ov[2*a+1]  = 1'b1;
            ovv[2*a+1] = ONE;
            dq   = $signed({3'b0, dd[a]});
            eq   = neg[a] ? q[2*a+1] : q[2*a];
            lq   = neg[a] ? q[2*a] : q[2*a+1];
            en_n = -eq;
            if (dd[a] == '0) begin
                if (q[2*a] < 0 || q[2*a+1] < 0) ok = 1'b0;
            end else begin
                if (en_n > 0) begin
                    if (en_n >= dq) begin
                        ovv[2*a] = (en_n == dq) ? ONE : ONE_P1;
                    end else begin
                        ov[2*a]  = 1'b0;
                        rem[2*a] = en_n[C-1:0];
                        den[2*a] = dd[a];
                    end
                end
                if (lq < 0) begin
                    ok = 1'b0;
                end else if (lq < dq) begin
                    ov[2*a+1]  = 1'b0;
                    rem[2*a+1] = lq[C-1:0];
                    den[2*a+1] = dd[a];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
        if (i_en) begin
            o_flags <= '{ok: ok, neg_x: dx[C], neg_y: dy[C]};
            o_sx    <= i_sx;
            o_sy    <= i_sy;
            o_adx   <= adx_w[C-1:0];
            o_ady   <= ady_w[C-1:0];
            o_rem   <= rem;
            o_den   <= den;
            o_ov    <= ov;
            o_ovv   <= ovv;
        end
    end

endmodule

// ===== src/scl_div_stage.sv =====
module scl_div_stage #(
    parameter int COORD_BITS  = scl_pkg::COORD_BITS_DEF,
    parameter int U_FRAC_BITS = scl_pkg::U_FRAC_BITS_DEF,
    parameter int SIDE_BITS   = 1
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_en,
    input  logic                                          i_valid,
    input  logic [SIDE_BITS-1:0]                          i_side,
    input  logic [scl_pkg::N_LANES-1:0][COORD_BITS-1:0]   i_rem,
    input  logic [scl_pkg::N_LANES-1:0][COORD_BITS-1:0]   i_den,
    input  logic [scl_pkg::N_LANES-1:0][U_FRAC_BITS-1:0]  i_quo,
    output logic                                          o_valid,
    output logic [SIDE_BITS-1:0]                          o_side,
    output logic [scl_pkg::N_LANES-1:0][COORD_BITS-1:0]   o_rem,
    output logic [scl_pkg::N_LANES-1:0][COORD_BITS-1:0]   o_den,
    output logic [scl_pkg::N_LANES-1:0][U_FRAC_BITS-1:0]  o_quo
);
    import scl_pkg::*;

    localparam int C = COORD_BITS;
    localparam int U = U_FRAC_BITS;

    logic [C:0]                sh [N_LANES];
    logic [N_LANES-1:0][C-1:0] n_rem;
    logic [N_LANES-1:0][U-1:0] n_quo;

    always_comb begin
        for (int l = 0; l < N_LANES; l++) begin
            sh[l] = {i_rem[l], 1'b0};
            if (sh[l] >= {1'b0, i_den[l]}) begin
                n_rem[l] = C'(sh[l] - {1'b0, i_den[l]});
                n_quo[l] = {i_quo[l][U-2:0], 1'b1};
            end else begin
                n_rem[l] = sh[l][C-1:0];
                n_quo[l] = {i_quo[l][U-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
        if (i_en) begin
            o_side <= i_side;
            o_rem  <= n_rem;
            o_den  <= i_den;
            o_quo  <= n_quo;
        end
    end

endmodule

// ===== src/scl_back.sv =====
module scl_back #(
    parameter int COORD_BITS  = scl_pkg::COORD_BITS_DEF,
    parameter int U_FRAC_BITS = scl_pkg::U_FRAC_BITS_DEF
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_en,
    input  logic                                          i_valid,
    input  scl_pkg::t_flags                               i_flags,
    input  logic signed [COORD_BITS-1:0]                  i_sx,
    input  logic signed [COORD_BITS-1:0]                  i_sy,
    input  logic        [COORD_BITS-1:0]                  i_adx,
    input  logic        [COORD_BITS-1:0]                  i_ady,
    input  logic [scl_pkg::N_LANES-1:0][U_FRAC_BITS-1:0]  i_quo,
    input  logic [scl_pkg::N_LANES-1:0]                   i_ov,
    input  logic [scl_pkg::N_LANES-1:0][U_FRAC_BITS+1:0]  i_ovv,
    input  logic [scl_pkg::TOL_BITS-1:0]                  i_tol,
    output logic                                          o_valid,
    output logic                                          o_hit,
    output logic signed [COORD_BITS-1:0]                  o_entry_x,
    output logic signed [COORD_BITS-1:0]                  o_entry_y
);
    import scl_pkg::*;

    localparam int C  = COORD_BITS;
    localparam int U  = U_FRAC_BITS;
    localparam int LW = (2*C+3 > 2*TOL_BITS) ? 2*C+2*U+3 : 2*TOL_BITS+2*U;

    // stage 1: bounds
    logic [U+1:0] v [N_LANES];
    logic [U+1:0] u1, u2;
    logic         r1_valid, r1_ok, r1_nx, r1_ny;
    logic [U+1:0] r1_u1;
    logic [U:0]   r1_du;
    logic [C-1:0] r1_adx, r1_ady;
    logic signed [C-1:0] r1_sx, r1_sy;

    always_comb begin
        for (int l = 0; l < N_LANES; l++) begin
            v[l] = i_ov[l] ? i_ovv[l] : {2'b0, i_quo[l]};
        end
        u1 = (v[LANE_ENTER_X] > v[LANE_ENTER_Y]) ? v[LANE_ENTER_X] : v[LANE_ENTER_Y];
        u2 = (v[LANE_LEAVE_X] < v[LANE_LEAVE_Y]) ? v[LANE_LEAVE_X] : v[LANE_LEAVE_Y];
    end

    // stage 2: products
    logic           r2_valid, r2_ok, r2_nx, r2_ny;
    logic [2*C-1:0] r2_x2, r2_y2;
    logic [2*U+1:0] r2_d2;
    logic [C+U:0]   r2_px, r2_py;
    logic signed [C-1:0] r2_sx, r2_sy;

    // stage 3: length product, entry point
    logic [2*C:0]   s;
    logic [C-1:0]   ox, oy;
    logic signed [C:0] nx, ny;
    logic           r3_valid, r3_ok;
    logic [LW-1:0]  r3_lhs;
    logic signed [C-1:0] r3_ex, r3_ey;

    logic [2*TOL_BITS-1:0] r_tol_sq;
    logic [LW-1:0]         rhs;

    always_comb begin
        s   = {1'b0, r2_x2} + {1'b0, r2_y2};
        ox  = r2_px[C+U-1:U];
        oy  = r2_py[C+U-1:U];
        nx  = r2_nx ? ({r2_sx[C-1], r2_sx} - {1'b0, ox}) : ({r2_sx[C-1], r2_sx} + {1'b0, ox});
        ny  = r2_ny ? ({r2_sy[C-1], r2_sy} - {1'b0, oy}) : ({r2_sy[C-1], r2_sy} + {1'b0, oy});
        rhs = LW'({r_tol_sq, {(2*U){1'b0}}});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            o_valid  <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            o_valid  <= r3_valid;
        end
        r_tol_sq <= i_tol * i_tol;
        if (i_en) begin
            r1_ok  <= i_flags.ok && (u1 <= u2);
            r1_nx  <= i_flags.neg_x;
            r1_ny  <= i_flags.neg_y;
            r1_u1  <= u1;
            r1_du  <= (U+1)'(u2 - u1);
            r1_adx <= i_adx;
            r1_ady <= i_ady;
            r1_sx  <= i_sx;
            r1_sy  <= i_sy;

            r2_ok  <= r1_ok;
            r2_nx  <= r1_nx;
            r2_ny  <= r1_ny;
            r2_x2  <= r1_adx * r1_adx;
            r2_y2  <= r1_ady * r1_ady;
            r2_d2  <= r1_du * r1_du;
            r2_px  <= r1_adx * r1_u1[U:0];
            r2_py  <= r1_ady * r1_u1[U:0];
            r2_sx  <= r1_sx;
            r2_sy  <= r1_sy;

            r3_ok  <= r2_ok;
            r3_lhs <= LW'(s) * LW'(r2_d2);
            r3_ex  <= nx[C-1:0];
            r3_ey  <= ny[C-1:0];

            o_hit     <= r3_ok && (r3_lhs > rhs);
            o_entry_x <= (r3_ok && (r3_lhs > rhs)) ? r3_ex : '0;
            o_entry_y <= (r3_ok && (r3_lhs > rhs)) ? r3_ey : '0;
        end
    end

endmodule

// ===== src/segment_rect_clip_top.sv =====
// channel  dir  modport  payload
// i_in     in   sink     start_x start_y end_x end_y rect_left rect_top rect_width rect_height
// o_out    out  source   hit entry_x entry_y
// cfg      in   -        i_cfg_we, i_cfg_data (tolerance)
//
// One transfer accepted per cycle unless o_out stalls; each item yields one result
// through one setup stage, one restoring divider step per fraction bit across four
// lanes, then bounds, products, length and output.
// Reset clears the valid bits and the tolerance register to zero.
// A stall on o_out freezes every stage at once; i_in.ready follows it.
module segment_rect_clip_top #(
    parameter int COORD_BITS  = scl_pkg::COORD_BITS_DEF,
    parameter int U_FRAC_BITS = scl_pkg::U_FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    scl_seg_if.sink                       i_in,
    scl_res_if.source                     o_out,
    input  logic                          i_cfg_we,
    input  logic [scl_pkg::TOL_BITS-1:0]  i_cfg_data
);
    import scl_pkg::*;

    localparam int C  = COORD_BITS;
    localparam int U  = U_FRAC_BITS;
    localparam int FW = $bits(t_flags);
    localparam int SW = 4*C + FW + N_LANES + N_LANES*(U+2);

    logic [TOL_BITS-1:0] r_tol;
    logic                en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= '0;
        end else if (i_cfg_we) begin
            r_tol <= i_cfg_data;
        end
    end

    assign en         = !o_out.valid || o_out.ready;
    assign i_in.ready = en;

    logic                      f_valid;
    t_flags                    f_flags;
    logic signed [C-1:0]       f_sx, f_sy;
    logic [C-1:0]              f_adx, f_ady;
    logic [N_LANES-1:0][C-1:0] f_rem, f_den;
    logic [N_LANES-1:0]        f_ov;
    logic [N_LANES-1:0][U+1:0] f_ovv;

    scl_front #(.COORD_BITS(C), .U_FRAC_BITS(U)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in.valid),
        .i_sx    (i_in.start_x),
        .i_sy    (i_in.start_y),
        .i_ex    (i_in.end_x),
        .i_ey    (i_in.end_y),
        .i_rl    (i_in.rect_left),
        .i_rt    (i_in.rect_top),
        .i_rw    (i_in.rect_width),
        .i_rh    (i_in.rect_height),
        .o_valid (f_valid),
        .o_flags (f_flags),
        .o_sx    (f_sx),
        .o_sy    (f_sy),
        .o_adx   (f_adx),
        .o_ady   (f_ady),
        .o_rem   (f_rem),
        .o_den   (f_den),
        .o_ov    (f_ov),
        .o_ovv   (f_ovv)
    );

    logic                      c_valid [U+1];
    logic [SW-1:0]             c_side  [U+1];
    logic [N_LANES-1:0][C-1:0] c_rem   [U+1];
    logic [N_LANES-1:0][C-1:0] c_den   [U+1];
    logic [N_LANES-1:0][U-1:0] c_quo   [U+1];

    assign c_valid[0] = f_valid;
    assign c_side[0]  = {f_sx, f_sy, f_adx, f_ady, f_flags, f_ov, f_ovv};
    assign c_rem[0]   = f_rem;
    assign c_den[0]   = f_den;
    assign c_quo[0]   = '0;

    for (genvar g = 0; g < U; g++) begin : g_div
        scl_div_stage #(.COORD_BITS(C), .U_FRAC_BITS(U), .SIDE_BITS(SW)) u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (c_valid[g]),
            .i_side  (c_side[g]),
            .i_rem   (c_rem[g]),
            .i_den   (c_den[g]),
            .i_quo   (c_quo[g]),
            .o_valid (c_valid[g+1]),
            .o_side  (c_side[g+1]),
            .o_rem   (c_rem[g+1]),
            .o_den   (c_den[g+1]),
            .o_quo   (c_quo[g+1])
        );
    end

    logic signed [C-1:0]       b_sx, b_sy;
    logic [C-1:0]              b_adx, b_ady;
    t_flags                    b_flags;
    logic [N_LANES-1:0]        b_ov;
    logic [N_LANES-1:0][U+1:0] b_ovv;

    assign {b_sx, b_sy, b_adx, b_ady, b_flags, b_ov, b_ovv} = c_side[U];

    scl_back #(.COORD_BITS(C), .U_FRAC_BITS(U)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (c_valid[U]),
        .i_flags   (b_flags),
        .i_sx      (b_sx),
        .i_sy      (b_sy),
        .i_adx     (b_adx),
        .i_ady     (b_ady),
        .i_quo     (c_quo[U]),
        .i_ov      (b_ov),
        .i_ovv     (b_ovv),
        .i_tol     (r_tol),
        .o_valid   (o_out.valid),
        .o_hit     (o_out.hit),
        .o_entry_x (o_out.entry_x),
        .o_entry_y (o_out.entry_y)
    );

endmodule

// ===== src/scl_checker.sv =====
module scl_checker #(
    parameter int COORD_BITS = scl_pkg::COORD_BITS_DEF
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_ready,
    input logic                  i_out_valid,
    input logic                  i_out_ready,
    input logic                  i_hit,
    input logic [COORD_BITS-1:0] i_entry_x,
    input logic [COORD_BITS-1:0] i_entry_y
);

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_hit) |-> (i_entry_x == '0 && i_entry_y == '0))
        else $error("miss with nonzero entry point");

    a_ready_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_ready == (!i_out_valid || i_out_ready))
        else $error("input ready does not follow output stall");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_hit) && $stable(i_entry_x) && $stable(i_entry_y)))
        else $error("stalled result changed");

endmodule

bind segment_rect_clip_top scl_checker #(.COORD_BITS(COORD_BITS)) u_scl_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_hit       (o_out.hit),
    .i_entry_x   (o_out.entry_x),
    .i_entry_y   (o_out.entry_y)
);

// ===== tb/tb_segment_rect_clip_top.sv =====
module tb_segment_rect_clip_top;

    localparam int CB = scl_pkg::COORD_BITS_DEF;
    localparam int UF = scl_pkg::U_FRAC_BITS_DEF;
    localparam int TB = scl_pkg::TOL_BITS;
    localparam int LATENCY = UF + 5;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam longint UONE = 64'd1 << UF;

    typedef struct {
        logic signed [CB-1:0] sx, sy, ex, ey, rl, rt;
        logic [CB-2:0] rw, rh;
    } seg_t;

    typedef struct {
        logic hit;
        logic signed [CB-1:0] x, y;
    } clip_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [TB-1:0] i_cfg_data = '0;

    scl_seg_if #(.COORD_BITS(CB)) seg_ch ();
    scl_res_if #(.COORD_BITS(CB)) res_ch ();

    segment_rect_clip_top #(.COORD_BITS(CB), .U_FRAC_BITS(UF)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(seg_ch.sink), .o_out(res_ch.source),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    logic [TB-1:0] tol_model = '0;
    clip_t expected_clips[$];
    int errors = 0;
    int idle_pct = 26;
    bit hold_off = 1'b0;
    int hits = 0;
    int misses = 0;
    int idle_cycles = 0;

    initial begin
        seg_ch.valid = 1'b0;
        seg_ch.start_x = '0;
        seg_ch.start_y = '0;
        seg_ch.end_x = '0;
        seg_ch.end_y = '0;
        seg_ch.rect_left = '0;
        seg_ch.rect_top = '0;
        seg_ch.rect_width = '0;
        seg_ch.rect_height = '0;
        res_ch.ready = 1'b0;
    end

    // floor(n * 2^UF / d), 0 <= n < d
    function automatic longint clip_frac(longint n, longint d);
        return (n << UF) / d;
    endfunction

    function automatic clip_t clip_segment(seg_t s, logic [TB-1:0] tol);
        longint sx, sy, dx, dy, n, d, v, u1, u2, du, ox, oy;
        longint p[4], q[4];
        logic [255:0] lhs, rhs;
        bit ok;
        clip_t r;
        sx = s.sx; sy = s.sy;
        dx = longint'(s.ex) - sx;
        dy = longint'(s.ey) - sy;
        p[0] = -dx; p[1] = dx; p[2] = -dy; p[3] = dy;
        q[0] = sx - s.rl;
        q[1] = longint'(s.rl) + longint'(s.rw) - sx;
        q[2] = sy - s.rt;
        q[3] = longint'(s.rt) + longint'(s.rh) - sy;
        u1 = 0; u2 = UONE; ok = 1'b1;
        for (int k = 0; k < 4; k++) begin
            if (!ok) break;
            if (p[k] == 0) begin
                if (q[k] < 0) ok = 1'b0;
            end else if (p[k] < 0) begin
                n = -q[k]; d = -p[k];
                if (n > 0) begin
                    if (n >= d) v = (n == d) ? UONE : UONE + 1;
                    else v = clip_frac(n, d);
                    if (v > u1) u1 = v;
                end
            end else begin
                if (q[k] < 0) ok = 1'b0;
                else if (q[k] < p[k]) begin
                    v = clip_frac(q[k], p[k]);
                    if (v < u2) u2 = v;
                end
            end
        end
        if (ok && u1 > u2) ok = 1'b0;
        if (ok) begin
            du = u2 - u1;
            lhs = (256'(dx * dx) + 256'(dy * dy)) * 256'(du) * 256'(du);
            rhs = 256'(tol) * 256'(tol) * 256'(UONE) * 256'(UONE);
            if (lhs <= rhs) ok = 1'b0;
        end
        r.hit = ok; r.x = '0; r.y = '0;
        if (ok) begin
            ox = ((dx < 0 ? -dx : dx) * u1) >>> UF;
            oy = ((dy < 0 ? -dy : dy) * u1) >>> UF;
            r.x = CB'(dx < 0 ? sx - ox : sx + ox);
            r.y = CB'(dy < 0 ? sy - oy : sy + oy);
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    task automatic send_segment(seg_t s);
        if ($urandom_range(99) < idle_pct) begin
            seg_ch.valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < idle_pct) @(posedge i_clk);
        end
        seg_ch.valid <= 1'b1;
        seg_ch.start_x <= s.sx;
        seg_ch.start_y <= s.sy;
        seg_ch.end_x <= s.ex;
        seg_ch.end_y <= s.ey;
        seg_ch.rect_left <= s.rl;
        seg_ch.rect_top <= s.rt;
        seg_ch.rect_width <= s.rw;
        seg_ch.rect_height <= s.rh;
        @(posedge i_clk);
        while (!seg_ch.ready) @(posedge i_clk);
        expected_clips = {expected_clips, clip_segment(s, tol_model)};
    endtask

    // result side: random ready, long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                if (expected_clips.size() == 0) begin
                    report_mismatch("unexpected transfer", 1, 0);
                end else begin
                    clip_t e;
                    e = expected_clips.pop_front();
                    if (res_ch.hit !== e.hit) report_mismatch("hit", res_ch.hit, e.hit);
                    if (res_ch.entry_x !== e.x) report_mismatch("entry_x", res_ch.entry_x, e.x);
                    if (res_ch.entry_y !== e.y) report_mismatch("entry_y", res_ch.entry_y, e.y);
                    if (e.hit) hits++; else misses++;
                end
            end
            res_ch.ready <= !hold_off && ($urandom_range(99) >= idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (seg_ch.valid && seg_ch.ready) || (res_ch.valid && res_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no transfer for %0d cycles", idle_cycles);
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic drain();
        seg_ch.valid <= 1'b0;
        while (expected_clips.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic set_tolerance(logic [TB-1:0] t);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_data <= t;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        tol_model = t;
    endtask

    function automatic seg_t make_seg(int sx, int sy, int ex, int ey, int rl, int rt,
                                      int rw, int rh);
        seg_t s;
        s.sx = CB'(sx); s.sy = CB'(sy); s.ex = CB'(ex); s.ey = CB'(ey);
        s.rl = CB'(rl); s.rt = CB'(rt); s.rw = (CB-1)'(rw); s.rh = (CB-1)'(rh);
        return s;
    endfunction

    function automatic seg_t random_seg();
        seg_t s;
        int span;
        int c;
        c = $urandom_range(9);
        if (c < 2) begin
            s.sx = CB'($urandom); s.sy = CB'($urandom);
            s.ex = CB'($urandom); s.ey = CB'($urandom);
            s.rl = CB'($urandom); s.rt = CB'($urandom);
            s.rw = (CB-1)'($urandom); s.rh = (CB-1)'($urandom);
        end else begin
            span = (c < 5) ? 200 : (c < 8 ? 2000 : 16000);
            s.rl = CB'(int'($urandom_range(2 * span)) - span);
            s.rt = CB'(int'($urandom_range(2 * span)) - span);
            s.rw = (CB-1)'($urandom_range(span));
            s.rh = (CB-1)'($urandom_range(span));
            s.sx = CB'(int'($urandom_range(4 * span)) - 2 * span);
            s.sy = CB'(int'($urandom_range(4 * span)) - 2 * span);
            s.ex = CB'(int'($urandom_range(4 * span)) - 2 * span);
            s.ey = CB'(int'($urandom_range(4 * span)) - 2 * span);
            if ($urandom_range(5) == 0) s.ex = s.sx;
            if ($urandom_range(5) == 0) s.ey = s.sy;
        end
        return s;
    endfunction

    task automatic test_directed();
        send_segment(make_seg(-100, 50, 300, 50, 0, 0, 200, 100));
        send_segment(make_seg(50, -100, 50, 300, 0, 0, 200, 100));
        send_segment(make_seg(50, -10, 150, -10, 0, 0, 200, 100));
        send_segment(make_seg(-10, 50, -10, 60, 0, 0, 200, 100));
        send_segment(make_seg(10, 10, 10, 10, 0, 0, 200, 100));
        send_segment(make_seg(-300, 50, -100, 50, 0, 0, 200, 100));
        send_segment(make_seg(-100, 50, 0, 50, 0, 0, 200, 100));
        send_segment(make_seg(300, 50, 250, 50, 0, 0, 200, 100));
        send_segment(make_seg(50, 50, 150, 60, 0, 0, 200, 100));
        send_segment(make_seg(-400, -300, 400, 300, -50, -50, 100, 100));
        send_segment(make_seg(-32768, -32768, 32767, 32767, -32768, -32768, 32767, 32767));
        send_segment(make_seg(32767, 32767, -32768, -32768, 0, 0, 32767, 32767));
        send_segment(make_seg(32767, -32768, -32768, 32767, -100, -100, 0, 0));
        send_segment(make_seg(0, 0, 100, 0, 0, 0, 0, 0));
        send_segment(make_seg(-1, -1, 1, 1, -1, -1, 32767, 32767));
        send_segment(make_seg(-200, 0, 200, 300, -100, -100, 200, 200));
        send_segment(make_seg(0, -200, 0, 200, 0, 0, 100, 100));
    endtask

    task automatic test_random(int count);
        repeat (count) send_segment(random_seg());
    endtask

    task automatic test_no_idle(int count);
        idle_pct = 0;
        test_random(count);
        idle_pct = 26;
    endtask

    task automatic test_backpressure();
        fork
            begin
                hold_off = 1'b1;
                repeat (200) @(posedge i_clk);
                hold_off = 1'b0;
            end
            test_random(80);
        join
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        set_tolerance(TB'(32767));
        test_directed();
        test_random(100);
        set_tolerance(TB'(16));
        test_directed();
        test_random(600);
        test_backpressure();
        set_tolerance(TB'(0));
        test_no_idle(400);
        test_random(500);
        set_tolerance(TB'($urandom_range(3000)));
        test_random(300);
        drain();
        $display("Covered directed edge cases, random clips at four tolerances");
        $display("Saw %0d hits and %0d misses", hits, misses);
        $display("Included a full-throughput stretch and a long output stall");
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
